// File: hdl/window_sigma_outlier_clamp_defines.svh
// Assertion macros for the window sigma outlier clamp.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef WINDOW_SIGMA_OUTLIER_CLAMP_DEFINES_SVH
`define WINDOW_SIGMA_OUTLIER_CLAMP_DEFINES_SVH

`ifndef SYNTH
`define WSOC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define WSOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WSOC_ASSERT(lbl, clk, rstn, prop, msg)
`define WSOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: hdl/wsoc_pkg.sv
// Shared sizes, codes, interface structs and helpers for the outlier clamp.
// No dependencies; imported by wsoc_chan_state, wsoc_stats, wsoc_divider and the top level.
`default_nettype none

package wsoc_pkg;

	localparam int CHANNELS    = 12;
	localparam int WINDOW      = 16;
	localparam int SAMPLE_BITS = 24;

	localparam int CH_W    = 4;
	localparam int SIG_W   = 8;
	localparam int SIG2_W  = 2 * SIG_W;
	localparam int PADDR_W = 3;
	localparam int MIN_FILL = 3;

	localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W  = $clog2(WINDOW);
	localparam int N_W    = $clog2(WINDOW + 1);
	localparam int DEPTH  = CHANNELS * WINDOW;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
	localparam int SQ_W   = 2 * SAMPLE_BITS;
	localparam int SQS_W  = 2 * SAMPLE_BITS + $clog2(WINDOW);
	localparam int DIFF_W = SAMPLE_BITS + N_W + 1;
	localparam int DEV_W  = DIFF_W;
	localparam int LHS_W  = 2 * DEV_W + 8;
	localparam int S2_W   = 2 * SUM_W;
	localparam int NQ_W   = SQS_W + N_W;
	localparam int VAR_W  = NQ_W;
	localparam int RHS_W  = VAR_W + SIG2_W;
	localparam int CMP_W  = (RHS_W > LHS_W) ? RHS_W : LHS_W;
	localparam int DIVN_W = SUM_W + 1;
	localparam int DIVD_W = N_W + 1;

	localparam logic [SIG_W-1:0] SIGMA_RESET = 8'd48;

	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic              clear;
		logic              bump;
		logic [CIDX_W-1:0] cidx;
	} chs_cmd_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [N_W-1:0]   cnt_next;
	} chs_stat_t;

	typedef struct packed {
		logic              start;
		logic [CIDX_W-1:0] cidx;
		logic [N_W-1:0]    cnt;
	} stats_req_t;

	typedef struct packed {
		logic              start;
		logic [DIVN_W-1:0] dividend;
		logic [DIVD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVN_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic chan_ok(input logic [CH_W-1:0] c);
		return int'(c) < CHANNELS;
	endfunction

	function automatic logic [ADDR_W-1:0] win_addr(input logic [CIDX_W-1:0] c,
		input logic [POS_W-1:0] p);
		return ADDR_W'(int'(c) * WINDOW + int'(p));
	endfunction

endpackage

`default_nettype wire

// File: hdl/wsoc_window_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependency.
`default_nettype none

module wsoc_window_ram #(
	parameter int DEPTH = 192,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/wsoc_chan_state.sv
// Per-channel ring write position and fill count.
// Depends on wsoc_pkg and the assertion macro header.
`default_nettype none
`include "window_sigma_outlier_clamp_defines.svh"

module wsoc_chan_state import wsoc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  chs_cmd_t  cmd,
	output chs_stat_t stat
);

	logic [POS_W-1:0] pos_q [CHANNELS];
	logic [N_W-1:0]   cnt_q [CHANNELS];

	logic             in_range;
	logic [POS_W-1:0] pos_rd;
	logic [N_W-1:0]   cnt_rd;

	assign in_range = int'(cmd.cidx) < CHANNELS;
	assign pos_rd   = in_range ? pos_q[cmd.cidx] : '0;
	assign cnt_rd   = in_range ? cnt_q[cmd.cidx] : '0;

	// fill count saturates once the window is full
	assign stat.pos      = pos_rd;
	assign stat.cnt_next = (cnt_rd == N_W'(WINDOW)) ? cnt_rd : cnt_rd + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c] <= '0;
				cnt_q[c] <= '0;
			end
		end else if (cmd.clear) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pos_q[c] <= '0;
				cnt_q[c] <= '0;
			end
		end else if (cmd.bump) begin
			pos_q[cmd.cidx] <= (pos_rd == POS_W'(WINDOW - 1)) ? '0 : pos_rd + 1'b1;
			cnt_q[cmd.cidx] <= stat.cnt_next;
		end
	end

	// until the window wraps, the write position equals the fill count
	`WSOC_ASSERT(a_pos_tracks_fill, clk, arst_n, in_range && (cnt_rd != N_W'(WINDOW)) |-> (pos_rd == POS_W'(cnt_rd)), "write position out of step with fill count")

endmodule

`default_nettype wire

// File: hdl/wsoc_stats.sv
// Window walk: reads a channel's stored samples one per cycle from the RAM,
// squares them and accumulates sum and sum of squares. Depends on wsoc_pkg.
`default_nettype none
`include "window_sigma_outlier_clamp_defines.svh"

module wsoc_stats import wsoc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stats_req_t                    req,
	output logic [ADDR_W-1:0]             raddr,
	input  logic signed [SAMPLE_BITS-1:0] rdata,
	output logic                          done,
	output logic signed [SUM_W-1:0]       sum,
	output logic [SQS_W-1:0]              sumsq
);

	logic              issue_q;
	logic [N_W-1:0]    idx_q;
	logic [N_W-1:0]    cnt_q;
	logic [CIDX_W-1:0] cidx_q;
	logic              rv_s1, last_s1, rv_s2, last_s2;
	logic              last_issue;

	logic signed [SAMPLE_BITS-1:0] v_s2;
	logic signed [SQ_W-1:0]        sq_s2;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQS_W-1:0]              sumsq_q;

	assign last_issue = (idx_q == cnt_q - 1'b1);
	assign raddr      = win_addr(cidx_q, idx_q[POS_W-1:0]);
	assign done       = rv_s2 & last_s2;
	assign sum        = sum_q;
	assign sumsq      = sumsq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			cidx_q  <= '0;
			rv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			rv_s2   <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			if (req.start) begin
				issue_q <= 1'b1;
				idx_q   <= '0;
				cnt_q   <= req.cnt;
				cidx_q  <= req.cidx;
			end else if (issue_q) begin
				idx_q <= idx_q + 1'b1;
				if (last_issue) begin
					issue_q <= 1'b0;
				end
			end
			// RAM data arrives in the cycle after the address
			rv_s1   <= issue_q;
			last_s1 <= issue_q & last_issue;
			rv_s2   <= rv_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1) begin
			v_s2  <= rdata;
			sq_s2 <= rdata * rdata;
		end
		if (req.start) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (rv_s2) begin
			sum_q   <= sum_q + SUM_W'(v_s2);
			sumsq_q <= sumsq_q + SQS_W'($unsigned(sq_s2));
		end
	end

	`WSOC_ASSERT(a_idx_bound, clk, arst_n, issue_q |-> (idx_q < cnt_q), "read index past fill count")
	`WSOC_ASSERT(a_done_drained, clk, arst_n, done |-> (!issue_q && !rv_s1), "walk done with reads in flight")
	`WSOC_ASSERT_NEXT(a_start_issues, clk, arst_n, req.start, issue_q, "walk started without reads")

endmodule

`default_nettype wire

// File: hdl/wsoc_divider.sv
// Restoring divider, one quotient bit per cycle, for the rounded window mean.
// Depends on wsoc_pkg and the assertion macro header.
`default_nettype none
`include "window_sigma_outlier_clamp_defines.svh"

module wsoc_divider import wsoc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIVN_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] dvs_q;

	logic [DIVD_W:0]   trial;
	logic [DIVD_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DIVN_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIVN_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVN_W-2:0], ge};
			rem_q <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
		end
	end

	`WSOC_ASSERT(a_no_restart, clk, arst_n, !(req.start && busy_q), "divider restarted while busy")

endmodule

`default_nettype wire

// File: hdl/window_sigma_outlier_clamp.sv
// Sliding-window sigma outlier clamp, top level; uses wsoc_pkg, wsoc_window_ram,
// wsoc_chan_state, wsoc_stats and wsoc_divider. Each filter transfer stores its
// sample in the channel's 16-deep ring (one shared RAM for all channels), then
// with n stored samples (n >= 3) walks the window one RAM read per cycle for sum
// and sum of squares, tests (n*x - S)^2 * 256 > sigma^2 * (n*Q - S^2) and, on an
// outlier, substitutes the mean rounded half away from zero. One item is worked
// at a time: a pass-through item (fewer than three samples) goes straight to
// the output state; a checked item passes the window walk and states S_M1,
// S_M2, S_M3 and S_CMP, a replaced item then the 29-step bit-serial divider.
// A new item is taken while a finished result waits on out_stall. A clear
// transfer resets all channel counts and gives no result;
// a channel number of CHANNELS or above is dropped. sigma_q4_4 sits at byte
// address 0 (unsigned Q4.4, reset 3.0) and should be written only while idle.
`default_nettype none
`include "window_sigma_outlier_clamp_defines.svh"

module window_sigma_outlier_clamp import wsoc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_W-1:0]            paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [CH_W-1:0]               channel,
	input  logic signed [SAMPLE_BITS-1:0] sample,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [CH_W-1:0]               out_channel,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          replaced
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_M1   = 3'd2;
	localparam logic [2:0] S_M2   = 3'd3;
	localparam logic [2:0] S_M3   = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	localparam logic REG_SIGMA = 1'b0;

	logic [2:0]       state_q;
	logic [SIG_W-1:0] sigma_q;
	logic             out_valid_q;

	logic             cfg_wr;
	logic             accept;
	logic             do_clear;
	logic             do_filt;
	logic             out_free;
	logic             load_out;
	logic             outlier;

	chs_cmd_t         chs_cmd;
	chs_stat_t        chs_stat;
	stats_req_t       st_req;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic [ADDR_W-1:0]             ram_raddr;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic                          st_done;
	logic signed [SUM_W-1:0]       st_sum;
	logic [SQS_W-1:0]              st_sumsq;

	// item registers
	logic [CH_W-1:0]               ch_q;
	logic signed [SAMPLE_BITS-1:0] val_q;
	logic [N_W-1:0]                n_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic                          rep_q;

	// variance test pipeline
	logic signed [DIFF_W-1:0]      nv_s1;
	logic [NQ_W-1:0]               nq_s1;
	logic [S2_W-1:0]               s2_s1;
	logic [SIG2_W-1:0]             sig2_s1;
	logic [DEV_W-1:0]              dev_s2;
	logic [VAR_W-1:0]              var_s2;
	logic [LHS_W-1:0]              lhs_s3;
	logic [RHS_W-1:0]              rhs_s3;

	logic [SUM_W-1:0]              mags;
	logic signed [DIFF_W-1:0]      diff;
	logic [VAR_W-1:0]              s2_ext;
	logic [2*DEV_W-1:0]            dev2;
	logic [SAMPLE_BITS-1:0]        quo;

	logic [CH_W-1:0]               out_channel_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                          replaced_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_SIGMA) ? {{(32 - SIG_W){1'b0}}, sigma_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
		end else if (cfg_wr && (paddr[2] == REG_SIGMA)) begin
			sigma_q <= pwdata[SIG_W-1:0];
		end
	end

	// input side
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign do_clear = accept & (op == OP_CLEAR);
	assign do_filt  = accept & (op == OP_FILTER) & chan_ok(channel);

	assign chs_cmd.clear = do_clear;
	assign chs_cmd.bump  = do_filt;
	assign chs_cmd.cidx  = CIDX_W'(channel);

	assign st_req.start = do_filt & (chs_stat.cnt_next >= N_W'(MIN_FILL));
	assign st_req.cidx  = CIDX_W'(channel);
	assign st_req.cnt   = chs_stat.cnt_next;

	wsoc_chan_state u_chan_state (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (chs_cmd),
		.stat   (chs_stat)
	);

	// the sample is written at the accept edge; the walk reads start in the following cycle
	wsoc_window_ram #(
		.DEPTH (DEPTH),
		.WIDTH (SAMPLE_BITS)
	) u_window_ram (
		.clk   (clk),
		.we    (do_filt),
		.waddr (win_addr(CIDX_W'(channel), chs_stat.pos)),
		.wdata (sample),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wsoc_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.raddr  (ram_raddr),
		.rdata  ($signed(ram_rdata)),
		.done   (st_done),
		.sum    (st_sum),
		.sumsq  (st_sumsq)
	);

	// arithmetic
	assign mags    = st_sum[SUM_W-1] ? $unsigned(-st_sum) : $unsigned(st_sum);
	assign diff    = nv_s1 - DIFF_W'(st_sum);
	assign s2_ext  = VAR_W'(s2_s1);
	assign dev2    = dev_s2 * dev_s2;
	assign outlier = CMP_W'(rhs_s3) < CMP_W'(lhs_s3);
	assign quo     = div_rsp.quotient[SAMPLE_BITS-1:0];

	// mean rounding: (2|S| + n) / (2n), sign restored afterwards
	assign div_req.start    = (state_q == S_CMP) & outlier;
	assign div_req.dividend = DIVN_W'({mags, 1'b0}) + DIVN_W'(n_q);
	assign div_req.divisor  = {n_q, 1'b0};

	wsoc_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output side
	assign out_free = ~out_valid_q | ~out_stall;
	assign load_out = (state_q == S_OUT) & out_free;

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign filtered    = filtered_q;
	assign replaced    = replaced_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (do_filt) begin
						state_q <= st_req.start ? S_ACC : S_OUT;
					end
				end
				S_ACC: begin
					if (st_done) begin
						state_q <= S_M1;
					end
				end
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_CMP;
				S_CMP: state_q <= outlier ? S_DIV : S_OUT;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_filt) begin
			ch_q  <= channel;
			val_q <= sample;
			n_q   <= chs_stat.cnt_next;
			res_q <= sample;
			rep_q <= 1'b0;
		end
		if (state_q == S_M1) begin
			nv_s1   <= val_q * $signed({1'b0, n_q});
			nq_s1   <= st_sumsq * n_q;
			s2_s1   <= mags * mags;
			sig2_s1 <= sigma_q * sigma_q;
		end
		if (state_q == S_M2) begin
			dev_s2 <= diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
			var_s2 <= (nq_s1 < s2_ext) ? '0 : nq_s1 - s2_ext;
		end
		if (state_q == S_M3) begin
			lhs_s3 <= {dev2, 8'h00};
			rhs_s3 <= var_s2 * sig2_s1;
		end
		if ((state_q == S_DIV) && div_rsp.done) begin
			res_q <= st_sum[SUM_W-1] ? -$signed(quo) : $signed(quo);
			rep_q <= 1'b1;
		end
		if (load_out) begin
			out_channel_q <= ch_q;
			filtered_q    <= res_q;
			replaced_q    <= rep_q;
		end
	end

	`WSOC_ASSERT(a_replace_fill, clk, arst_n, ((state_q == S_OUT) && rep_q) |-> (n_q >= N_W'(MIN_FILL)), "mean substituted with too few samples")

endmodule

`default_nettype wire
